@@ src/cte_pkg.sv @@
// Package for the calendar time set editor: event codes, field codes,
// payload and state structs, and the day-of-month limit function.
// No dependencies.
package cte_pkg;

  // Field widths
  localparam int unsigned YearW   = 7;
  localparam int unsigned MonthW  = 4;
  localparam int unsigned DayW    = 5;
  localparam int unsigned HourW   = 5;
  localparam int unsigned MinuteW = 6;
  localparam int unsigned SecondW = 6;
  localparam int unsigned CmdW    = 3;
  localparam int unsigned FieldW  = 3;
  localparam int unsigned PeriodW = 16;

  // Field ranges
  localparam logic [YearW-1:0]   YearMax   = 7'd99;
  localparam logic [MonthW-1:0]  MonthMin  = 4'd1;
  localparam logic [MonthW-1:0]  MonthMax  = 4'd12;
  localparam logic [DayW-1:0]    DayMin    = 5'd1;
  localparam logic [DayW-1:0]    DayMax    = 5'd31;
  localparam logic [HourW-1:0]   HourMax   = 5'd23;
  localparam logic [MinuteW-1:0] MinuteMax = 6'd59;
  localparam logic [SecondW-1:0] SecondMax = 6'd59;

  localparam logic [PeriodW-1:0] BlinkPeriodReset = 16'd1000;

  // Event codes; codes 6 and 7 carry no meaning
  typedef enum logic [CmdW-1:0] {
    CMD_TICK = 3'd0,
    CMD_MODE = 3'd1,
    CMD_NEXT = 3'd2,
    CMD_INC  = 3'd3,
    CMD_DEC  = 3'd4,
    CMD_LOAD = 3'd5
  } cte_cmd_e;

  // Field codes for the edit selection
  typedef enum logic [FieldW-1:0] {
    FLD_YEAR   = 3'd0,
    FLD_MONTH  = 3'd1,
    FLD_DAY    = 3'd2,
    FLD_HOUR   = 3'd3,
    FLD_MINUTE = 3'd4,
    FLD_SECOND = 3'd5
  } cte_field_e;

  typedef struct packed {
    logic [CmdW-1:0]    cmd;
    logic [YearW-1:0]   in_year;
    logic [MonthW-1:0]  in_month;
    logic [DayW-1:0]    in_day;
    logic [HourW-1:0]   in_hour;
    logic [MinuteW-1:0] in_minute;
    logic [SecondW-1:0] in_second;
  } cte_in_t;

  typedef struct packed {
    logic [YearW-1:0]   out_year;
    logic [MonthW-1:0]  out_month;
    logic [DayW-1:0]    out_day;
    logic [HourW-1:0]   out_hour;
    logic [MinuteW-1:0] out_minute;
    logic [SecondW-1:0] out_second;
    logic               set_mode;
    logic [FieldW-1:0]  selected_field;
    logic               blank_selected;
    logic               write_back;
  } cte_out_t;

  typedef struct packed {
    logic [YearW-1:0]   year;
    logic [MonthW-1:0]  month;
    logic [DayW-1:0]    day;
    logic [HourW-1:0]   hour;
    logic [MinuteW-1:0] minute;
    logic [SecondW-1:0] second;
    logic               edit_mode;
    cte_field_e         field_sel;
    logic               blink;
    logic [PeriodW-1:0] tick_count;
  } cte_state_t;

  // Last day of the month; every year divisible by four is leap
  function automatic logic [DayW-1:0] day_limit(input logic [MonthW-1:0] month,
                                                input logic [YearW-1:0] year);
    logic [DayW-1:0] lim;
    lim = DayMax;
    if (month == 4'd4 || month == 4'd6 || month == 4'd9 || month == 4'd11) begin
      lim = 5'd30;
    end else if (month == 4'd2) begin
      lim = (year[1:0] == 2'd0) ? 5'd29 : 5'd28;
    end
    return lim;
  endfunction

endpackage

@@ src/cte_stream_if.sv @@
// Valid/ready channel interface with a payload type parameter.
// Used for the event input, the result output and the config write port.
interface cte_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ src/cte_in_stage.sv @@
// Input register for event items.
// Depends on cte_pkg and cte_stream_if.
module cte_in_stage import cte_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  cte_stream_if.sink  in_i,
  output cte_in_t     item_o,
  output logic        valid_o,
  input  logic        take_i
);

  logic    valid_q, valid_d;
  cte_in_t item_q;

  // Accept a new item when empty or when the held one moves on this cycle
  assign in_i.ready = !valid_q || take_i;

  always_comb begin
    valid_d = valid_q;
    if (in_i.ready) begin
      valid_d = in_i.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Capture the payload on each transfer
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      item_q <= in_i.data;
    end
  end

  assign item_o  = item_q;
  assign valid_o = valid_q;

endmodule

@@ src/cte_edit_logic.sv @@
// Next-state logic of the editor: tick/blink, mode, field select, step up,
// step down and load. Depends on cte_pkg.
module cte_edit_logic import cte_pkg::*; (
  input  cte_state_t         state_i,
  input  cte_in_t            item_i,
  input  logic [PeriodW-1:0] period_i,
  output cte_state_t         state_o,
  output logic               write_back_o
);

  always_comb begin
    cte_state_t      s;
    logic [PeriodW-1:0] cnt_inc;
    logic [DayW:0]   day_wide;
    logic [DayW-1:0] lim;

    s            = state_i;
    write_back_o = 1'b0;
    cnt_inc      = state_i.tick_count + 16'd1;
    day_wide     = {1'b0, state_i.day};
    lim          = DayMax;

    unique case (item_i.cmd)
      CMD_TICK: begin
        // Advance the counter; toggle blink at the half period
        s.tick_count = cnt_inc;
        if (cnt_inc >= period_i) begin
          s.tick_count = '0;
          s.blink      = !state_i.blink;
        end
      end
      CMD_MODE: begin
        if (!state_i.edit_mode) begin
          s.edit_mode = 1'b1;
          s.field_sel = FLD_YEAR;
        end else begin
          s.edit_mode  = 1'b0;
          write_back_o = 1'b1;
        end
      end
      CMD_NEXT: begin
        if (state_i.edit_mode) begin
          if (state_i.field_sel >= FLD_SECOND) begin
            s.field_sel = FLD_YEAR;
          end else begin
            s.field_sel = cte_field_e'(state_i.field_sel + 3'd1);
          end
        end
      end
      CMD_INC: begin
        if (state_i.edit_mode) begin
          // Step the selected field up, wrapping to its minimum
          unique case (state_i.field_sel)
            FLD_YEAR:   s.year   = (state_i.year >= YearMax) ? '0 : state_i.year + 7'd1;
            FLD_MONTH:  s.month  = (state_i.month >= MonthMax) ? MonthMin
                                                               : state_i.month + 4'd1;
            FLD_DAY:    day_wide = {1'b0, state_i.day} + 6'd1;
            FLD_HOUR:   s.hour   = (state_i.hour >= HourMax) ? '0 : state_i.hour + 5'd1;
            FLD_MINUTE: s.minute = (state_i.minute >= MinuteMax) ? '0
                                                                 : state_i.minute + 6'd1;
            FLD_SECOND: s.second = (state_i.second >= SecondMax) ? '0
                                                                 : state_i.second + 6'd1;
            default: ;
          endcase
          // Check the day against the updated month and year
          lim = day_limit(s.month, s.year);
          if (day_wide > {1'b0, lim}) begin
            s.day = DayMin;
          end else begin
            s.day = day_wide[DayW-1:0];
          end
        end
      end
      CMD_DEC: begin
        if (state_i.edit_mode) begin
          lim = day_limit(state_i.month, state_i.year);
          // Step the selected field down, wrapping to its maximum
          unique case (state_i.field_sel)
            FLD_YEAR:   s.year   = (state_i.year == '0) ? YearMax : state_i.year - 7'd1;
            FLD_MONTH:  s.month  = (state_i.month <= MonthMin) ? MonthMax
                                                               : state_i.month - 4'd1;
            FLD_DAY:    s.day    = (state_i.day <= DayMin) ? lim : state_i.day - 5'd1;
            FLD_HOUR:   s.hour   = (state_i.hour == '0) ? HourMax : state_i.hour - 5'd1;
            FLD_MINUTE: s.minute = (state_i.minute == '0) ? MinuteMax
                                                          : state_i.minute - 6'd1;
            FLD_SECOND: s.second = (state_i.second == '0) ? SecondMax
                                                          : state_i.second - 6'd1;
            default: ;
          endcase
          if (s.day > day_limit(s.month, s.year)) begin
            s.day = DayMin;
          end
        end
      end
      CMD_LOAD: begin
        if (!state_i.edit_mode) begin
          // Saturate each loaded field into its range
          s.year   = (item_i.in_year > YearMax) ? YearMax : item_i.in_year;
          s.month  = (item_i.in_month < MonthMin) ? MonthMin :
                     (item_i.in_month > MonthMax) ? MonthMax : item_i.in_month;
          s.day    = (item_i.in_day < DayMin) ? DayMin : item_i.in_day;
          s.hour   = (item_i.in_hour > HourMax) ? HourMax : item_i.in_hour;
          s.minute = (item_i.in_minute > MinuteMax) ? MinuteMax : item_i.in_minute;
          s.second = (item_i.in_second > SecondMax) ? SecondMax : item_i.in_second;
        end
      end
      default: ;
    endcase

    state_o = s;
  end

endmodule

@@ src/calendar_time_set_editor.sv @@
// Top level of the calendar time set editor: input register, editor state,
// blink period register and result register.
// Depends on cte_pkg, cte_stream_if, cte_in_stage and cte_edit_logic.
//
// Each event item yields one result item holding the time, mode, selected
// field, blank flag and write-back flag after the event. An item passes the
// input register and then the result register, which loads once it is free
// or its result transfers out in that cycle. The editor state is updated in
// the same cycle the result register loads, so a new item is taken every
// cycle while the result side is ready to take each result.
// The blink half period register is written through the config channel,
// which is always ready, and should be written only while no item is in
// flight.
module calendar_time_set_editor import cte_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  cte_stream_if.sink   in_i,
  cte_stream_if.source out_o,
  cte_stream_if.sink   cfg_i
);

  cte_in_t            item;
  logic               item_valid;
  logic               advance;
  cte_state_t         state_q, state_d;
  logic               write_back;
  logic [PeriodW-1:0] period_q;
  logic               out_valid_q, out_valid_d;
  cte_out_t           out_q;

  cte_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .item_o  (item),
    .valid_o (item_valid),
    .take_i  (advance)
  );

  cte_edit_logic u_edit_logic (
    .state_i      (state_q),
    .item_i       (item),
    .period_i     (period_q),
    .state_o      (state_d),
    .write_back_o (write_back)
  );

  // Move the held item into the result register when that register frees up
  assign advance = item_valid && (!out_valid_q || out_o.ready);

  // Editor state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{year: '0, month: MonthMin, day: DayMin, hour: '0, minute: '0,
                   second: '0, edit_mode: 1'b0, field_sel: FLD_YEAR, blink: 1'b0,
                   tick_count: '0};
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Blink half period register
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= BlinkPeriodReset;
    end else if (cfg_i.valid) begin
      period_q <= cfg_i.data;
    end
  end

  // Result register valid: set on advance, drop on output transfer
  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload from the state after the event
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q.out_year       <= state_d.year;
      out_q.out_month      <= state_d.month;
      out_q.out_day        <= state_d.day;
      out_q.out_hour       <= state_d.hour;
      out_q.out_minute     <= state_d.minute;
      out_q.out_second     <= state_d.second;
      out_q.set_mode       <= state_d.edit_mode;
      out_q.selected_field <= FieldW'(state_d.field_sel);
      out_q.blank_selected <= state_d.edit_mode & state_d.blink;
      out_q.write_back     <= write_back;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  // Write-back only comes with the return to show mode
  a_wb_show: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.write_back |-> !out_q.set_mode)
    else $error("write_back raised while in set mode");

  // Blank only in set mode
  a_blank_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.blank_selected |-> out_q.set_mode)
    else $error("blank_selected raised in show mode");

  // Held time stays within its ranges
  a_ranges: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.month >= MonthMin && state_q.month <= MonthMax && state_q.day >= DayMin &&
    state_q.year <= YearMax && state_q.hour <= HourMax && state_q.minute <= MinuteMax &&
    state_q.second <= SecondMax)
    else $error("time field out of range");

  // State changes only when an item moves to the result register
  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(state_q))
    else $error("editor state changed without an item");

  // A stalled result is not overwritten
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_o.ready |-> !advance)
    else $error("result register overwritten while stalled");

endmodule

@@ tb/tb.sv @@
// Self-checking bench for calendar_time_set_editor: a tracker class predicts the
// time, mode, selection and blink outputs of every event and checks each result.
// Depends on cte_pkg and cte_stream_if.
module tb import cte_pkg::*;;

  typedef logic [PeriodW-1:0] period_t;

  // Event codes that the block ignores
  localparam logic [CmdW-1:0] CMD_SPARE_A = 3'd6;
  localparam logic [CmdW-1:0] CMD_SPARE_B = 3'd7;

  localparam int unsigned HoldCycles    = 300;
  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned PhaseItems    = 150;
  localparam int unsigned DrainCycles   = 4;

  // Tracks the editor state and holds the results still due
  class time_edit_tracker;
    bit [6:0]      cal [6];
    bit            editing;
    cte_field_e    sel;
    bit            blink;
    bit [15:0]     ticks;
    period_t       half_period;
    cte_out_t      due_q [$];
    int unsigned   mismatches;
    int unsigned   results_seen;

    function new();
      cal[FLD_YEAR]   = 7'd0;
      cal[FLD_MONTH]  = 7'(MonthMin);
      cal[FLD_DAY]    = 7'(DayMin);
      cal[FLD_HOUR]   = 7'd0;
      cal[FLD_MINUTE] = 7'd0;
      cal[FLD_SECOND] = 7'd0;
      editing      = 1'b0;
      sel          = FLD_YEAR;
      blink        = 1'b0;
      ticks        = '0;
      half_period  = BlinkPeriodReset;
      mismatches   = 0;
      results_seen = 0;
    endfunction

    function int pending();
      return due_q.size();
    endfunction

    // Last day of the held month; years divisible by four are leap
    function bit [6:0] month_len();
      case (cal[FLD_MONTH])
        7'd4, 7'd6, 7'd9, 7'd11: return 7'd30;
        7'd2:                    return (cal[FLD_YEAR] % 4 == 0) ? 7'd29 : 7'd28;
        default:                 return 7'(DayMax);
      endcase
    endfunction

    function bit [6:0] field_floor(int i);
      case (i)
        FLD_MONTH: return 7'(MonthMin);
        FLD_DAY:   return 7'(DayMin);
        default:   return 7'd0;
      endcase
    endfunction

    function bit [6:0] field_ceil(int i);
      case (i)
        FLD_YEAR:   return 7'(YearMax);
        FLD_MONTH:  return 7'(MonthMax);
        FLD_DAY:    return 7'(DayMax);
        FLD_HOUR:   return 7'(HourMax);
        FLD_MINUTE: return 7'(MinuteMax);
        default:    return 7'(SecondMax);
      endcase
    endfunction

    function bit [6:0] saturate(int unsigned v, int i);
      if (v < field_floor(i)) return field_floor(i);
      if (v > field_ceil(i)) return field_ceil(i);
      return 7'(v);
    endfunction

    // Step the selected field up, then wrap every field above its ceiling
    function void bump_up();
      bit [6:0] top;
      cal[sel] = cal[sel] + 7'd1;
      for (int i = 0; i < 6; i++) begin
        top = (i == FLD_DAY) ? month_len() : field_ceil(i);
        if (cal[i] > top) cal[i] = field_floor(i);
      end
    endfunction

    // Step the selected field down with wrap, then recheck the day
    function void bump_down();
      if (cal[sel] <= field_floor(int'(sel))) begin
        cal[sel] = (sel == FLD_DAY) ? month_len() : field_ceil(int'(sel));
      end else begin
        cal[sel] = cal[sel] - 7'd1;
      end
      if (cal[FLD_DAY] > month_len()) cal[FLD_DAY] = 7'(DayMin);
    endfunction

    // Apply one accepted event and queue the result it must produce
    function void note_event(cte_in_t ev);
      cte_out_t res;
      bit       wb;
      wb = 1'b0;
      case (ev.cmd)
        CMD_TICK: begin
          ticks = ticks + 16'd1;
          if (ticks >= half_period) begin
            ticks = '0;
            blink = ~blink;
          end
        end
        CMD_MODE: begin
          if (!editing) begin
            editing = 1'b1;
            sel     = FLD_YEAR;
          end else begin
            editing = 1'b0;
            wb      = 1'b1;
          end
        end
        CMD_NEXT: begin
          if (editing) sel = (sel == FLD_SECOND) ? FLD_YEAR : cte_field_e'(sel + 1);
        end
        CMD_INC: begin
          if (editing) bump_up();
        end
        CMD_DEC: begin
          if (editing) bump_down();
        end
        CMD_LOAD: begin
          if (!editing) begin
            cal[FLD_YEAR]   = saturate(32'(ev.in_year), int'(FLD_YEAR));
            cal[FLD_MONTH]  = saturate(32'(ev.in_month), int'(FLD_MONTH));
            cal[FLD_DAY]    = saturate(32'(ev.in_day), int'(FLD_DAY));
            cal[FLD_HOUR]   = saturate(32'(ev.in_hour), int'(FLD_HOUR));
            cal[FLD_MINUTE] = saturate(32'(ev.in_minute), int'(FLD_MINUTE));
            cal[FLD_SECOND] = saturate(32'(ev.in_second), int'(FLD_SECOND));
          end
        end
        default: ;
      endcase
      res.out_year       = cal[FLD_YEAR][YearW-1:0];
      res.out_month      = cal[FLD_MONTH][MonthW-1:0];
      res.out_day        = cal[FLD_DAY][DayW-1:0];
      res.out_hour       = cal[FLD_HOUR][HourW-1:0];
      res.out_minute     = cal[FLD_MINUTE][MinuteW-1:0];
      res.out_second     = cal[FLD_SECOND][SecondW-1:0];
      res.set_mode       = editing;
      res.selected_field = sel;
      res.blank_selected = editing & blink;
      res.write_back     = wb;
      due_q.push_back(res);
    endfunction

    task report_mismatch(string msg);
      $display("ERROR result %0d: %s", results_seen, msg);
      mismatches++;
    endtask

    task check_field(string name, int unsigned got, int unsigned want);
      if (got != want) report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
    endtask

    // Compare one result against the oldest one due
    task check_result(cte_out_t got);
      cte_out_t want;
      results_seen++;
      if (due_q.size() == 0) begin
        report_mismatch("result arrived with none due");
        return;
      end
      want = due_q.pop_front();
      check_field("out_year", 32'(got.out_year), 32'(want.out_year));
      check_field("out_month", 32'(got.out_month), 32'(want.out_month));
      check_field("out_day", 32'(got.out_day), 32'(want.out_day));
      check_field("out_hour", 32'(got.out_hour), 32'(want.out_hour));
      check_field("out_minute", 32'(got.out_minute), 32'(want.out_minute));
      check_field("out_second", 32'(got.out_second), 32'(want.out_second));
      check_field("set_mode", 32'(got.set_mode), 32'(want.set_mode));
      check_field("selected_field", 32'(got.selected_field), 32'(want.selected_field));
      check_field("blank_selected", 32'(got.blank_selected), 32'(want.blank_selected));
      check_field("write_back", 32'(got.write_back), 32'(want.write_back));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;
  bit   hold_req;
  int   burst_left;
  int   idle_cycles;

  cte_stream_if #(.T(cte_in_t))  ev_if  ();
  cte_stream_if #(.T(cte_out_t)) res_if ();
  cte_stream_if #(.T(period_t))  cfg_if ();

  time_edit_tracker tracker = new();

  calendar_time_set_editor i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (ev_if),
    .out_o  (res_if),
    .cfg_i  (cfg_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Track accepted events and check accepted results
  always @(posedge clk) begin
    if (ev_if.valid && ev_if.ready) tracker.note_event(ev_if.data);
    if (res_if.valid && res_if.ready) tracker.check_result(res_if.data);
  end

  // Abort when no transfer happens for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((ev_if.valid && ev_if.ready) || (res_if.valid && res_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WatchdogLimit) begin
        $display("watchdog: no transfer for %0d cycles", idle_cycles);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Result side: switch between stall styles; hold off once on request
  initial begin : receiver
    int style;
    int span;
    wait (rst_n === 1'b1);
    forever begin
      style = $urandom_range(0, 3);
      span  = $urandom_range(10, 120);
      for (int n = 0; n < span; n++) begin
        @(negedge clk);
        if (hold_req) begin
          res_if.ready = 1'b0;
          repeat (HoldCycles) @(negedge clk);
          hold_req = 1'b0;
        end else begin
          case (style)
            0:       res_if.ready = 1'b1;
            1:       res_if.ready = 1'($urandom_range(0, 1));
            2:       res_if.ready = (n % 4 == 0);
            default: res_if.ready = ($urandom_range(0, 7) != 0);
          endcase
        end
      end
    end
  end

  function automatic cte_in_t noise_payload(logic [CmdW-1:0] cmd);
    cte_in_t ev;
    ev.cmd       = cmd;
    ev.in_year   = YearW'($urandom_range(0, 127));
    ev.in_month  = MonthW'($urandom_range(0, 15));
    ev.in_day    = DayW'($urandom_range(0, 31));
    ev.in_hour   = HourW'($urandom_range(0, 31));
    ev.in_minute = MinuteW'($urandom_range(0, 63));
    ev.in_second = SecondW'($urandom_range(0, 63));
    return ev;
  endfunction

  function automatic cte_in_t valid_load();
    cte_in_t ev;
    ev.cmd       = CMD_LOAD;
    ev.in_year   = YearW'($urandom_range(0, 99));
    ev.in_month  = MonthW'($urandom_range(1, 12));
    ev.in_day    = ($urandom_range(0, 1) == 0) ? DayW'($urandom_range(28, 31))
                                               : DayW'($urandom_range(1, 31));
    ev.in_hour   = HourW'($urandom_range(0, 23));
    ev.in_minute = MinuteW'($urandom_range(0, 59));
    ev.in_second = SecondW'($urandom_range(0, 59));
    return ev;
  endfunction

  // Offer one event in bursts with random gaps; return once it transfers
  task automatic send_event(input cte_in_t ev);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        ev_if.valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    ev_if.valid = 1'b1;
    ev_if.data  = ev;
    do @(posedge clk); while (!ev_if.ready);
  endtask

  task automatic send_cmd(input logic [CmdW-1:0] cmd);
    send_event(noise_payload(cmd));
  endtask

  task automatic send_load(input int y, input int mo, input int d, input int h,
                           input int mi, input int s);
    cte_in_t ev;
    ev.cmd       = CMD_LOAD;
    ev.in_year   = YearW'(y);
    ev.in_month  = MonthW'(mo);
    ev.in_day    = DayW'(d);
    ev.in_hour   = HourW'(h);
    ev.in_minute = MinuteW'(mi);
    ev.in_second = SecondW'(s);
    send_event(ev);
  endtask

  // Drop valid and let every due result drain before touching the register
  task automatic wait_idle();
    @(negedge clk);
    ev_if.valid = 1'b0;
    burst_left  = 0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  task automatic write_period(input period_t v);
    @(negedge clk);
    cfg_if.valid = 1'b1;
    cfg_if.data  = v;
    do @(posedge clk); while (!cfg_if.ready);
    tracker.half_period = v;
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  task automatic run_directed();
    // Saturating, clearing and unchecked loads
    send_load(127, 15, 31, 31, 63, 63);
    send_load(0, 0, 0, 0, 0, 0);
    send_load(99, 2, 29, 23, 59, 59);
    // Keys in show mode and unused codes do nothing
    send_cmd(CMD_NEXT);
    send_cmd(CMD_INC);
    send_cmd(CMD_DEC);
    send_cmd(CMD_SPARE_A);
    send_cmd(CMD_SPARE_B);
    send_cmd(CMD_TICK);
    // Enter set mode; load is ignored there
    send_cmd(CMD_MODE);
    send_load(127, 15, 31, 31, 63, 63);
    // Year wraps to 0 (leap keeps Feb 29), then back to 99 (day drops to 1)
    send_cmd(CMD_INC);
    send_cmd(CMD_DEC);
    // Month wraps both ways
    send_cmd(CMD_NEXT);
    send_cmd(CMD_DEC);
    send_cmd(CMD_DEC);
    send_cmd(CMD_INC);
    // Day wraps to the month limit
    send_cmd(CMD_NEXT);
    send_cmd(CMD_DEC);
    // Hour and minute wrap at the top, second steps down
    send_cmd(CMD_NEXT);
    send_cmd(CMD_INC);
    send_cmd(CMD_NEXT);
    send_cmd(CMD_INC);
    send_cmd(CMD_NEXT);
    send_cmd(CMD_DEC);
    // Selection wraps, then leave set mode with write-back
    send_cmd(CMD_NEXT);
    send_cmd(CMD_MODE);
  endtask

  // Mostly edit sessions and show-mode loads; some tick runs and raw noise
  task automatic run_random(input int quota);
    int sent;
    int pick;
    int k;
    logic [CmdW-1:0] cmd;
    sent = 0;
    while (sent < quota) begin
      pick = $urandom_range(0, 9);
      if (pick <= 5) begin
        send_cmd(CMD_MODE);
        k = $urandom_range(1, 24);
        repeat (k) begin
          pick = $urandom_range(0, 19);
          if (pick < 6)       cmd = CMD_NEXT;
          else if (pick < 12) cmd = CMD_INC;
          else if (pick < 18) cmd = CMD_DEC;
          else if (pick < 19) cmd = CMD_TICK;
          else                cmd = ($urandom_range(0, 1) == 0) ? CMD_LOAD : CMD_SPARE_A;
          send_cmd(cmd);
          if (cmd != CMD_SPARE_A && cmd != CMD_LOAD) sent++;
        end
        send_cmd(CMD_MODE);
        sent += 2;
      end else if (pick <= 7) begin
        k = $urandom_range(1, 6);
        repeat (k) begin
          if ($urandom_range(0, 3) == 0) send_event(noise_payload(CMD_LOAD));
          else send_event(valid_load());
          if ($urandom_range(0, 1) == 0) send_cmd(CMD_TICK);
          sent += 2;
        end
      end else if (pick == 8) begin
        k = $urandom_range(1, 30);
        repeat (k) send_cmd(CMD_TICK);
        sent += k;
      end else begin
        cmd = CmdW'($urandom_range(0, 7));
        send_cmd(cmd);
        if (cmd != CMD_SPARE_A && cmd != CMD_SPARE_B) sent++;
      end
    end
  endtask

  initial begin
    period_t plan [6];
    ev_if.valid  = 1'b0;
    ev_if.data   = '0;
    res_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.data  = '0;
    hold_req     = 1'b0;
    burst_left   = 0;
    idle_cycles  = 0;
    rst_n        = 1'b0;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    run_directed();

    // Zero toggles blink on every tick; the top value practically never does
    plan[0] = 16'd0;
    plan[1] = 16'd1;
    plan[2] = 16'hFFFF;
    plan[3] = 16'd2;
    plan[4] = PeriodW'($urandom_range(3, 40));
    plan[5] = BlinkPeriodReset;
    for (int p = 0; p < 6; p++) begin
      wait_idle();
      write_period(plan[p]);
      if (p == 0) hold_req = 1'b1;
      run_random(PhaseItems);
    end

    // Drain the last results, then allow a few quiet cycles
    @(negedge clk);
    ev_if.valid = 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (tracker.mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/cte_pkg.sv
src/cte_stream_if.sv
src/cte_in_stage.sv
src/cte_edit_logic.sv
src/calendar_time_set_editor.sv
tb/tb.sv
